// File: rtl/dcs_pkg.sv
// dcs_pkg: shared types, constants and constant tables for the dtw curve similarity core
// depends on nothing; imported by dcs_ctrl, dcs_datapath and the top level
`default_nettype none

package dcs_pkg;

	// field widths
	localparam int DEF_MAX_LEN = 64;
	localparam int MODE_W      = 2;
	localparam int LAT_W       = 24;
	localparam int LOG_W       = 16;
	localparam int COST_W      = 24;
	localparam int SIM_W       = 16;
	localparam int MANT_W      = 31;
	localparam int ROOT_W      = 30;
	localparam int FRAC_STEPS  = 16;
	localparam int DIV_STEPS   = COST_W;

	// fixed point constants
	localparam logic [COST_W-1:0] INF_COST  = 24'hFFFFFF;
	localparam logic [15:0]       LN2_Q16   = 16'd45426;
	localparam logic [16:0]       K_Q16     = 17'd75366;
	localparam logic [16:0]       LOG2E_Q16 = 17'd94548;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A   = 2'd0,
		MODE_STREAM_B = 2'd1,
		MODE_FINISH   = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LN,
		S_LNFIN,
		S_ASTORE,
		S_USTART,
		S_UPD,
		S_FREAD,
		S_DSTART,
		S_DIV,
		S_MUL1,
		S_MUL2,
		S_EXP,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       capture;
		logic       mark_drop;
		logic       ln_step;
		logic       ln_fin;
		logic       a_store;
		logic       upd_start;
		logic       upd_step;
		logic       upd_done;
		logic       fin_read;
		logic       div_start;
		logic       div_step;
		logic       mul1;
		logic       mul2;
		logic       exp_step;
		logic       out_load;
		logic       clear;
		logic [3:0] step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic drop_a;
		logic drop_b;
		logic empty;
		logic load_a;
		logic upd_fin;
		logic out_free;
	} sts_t;

	typedef logic [ROOT_W-1:0] root_tbl_t [FRAC_STEPS];

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = x_in;
		r = '0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > x)
				b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// 2^(-2^-k) in q0.30 for k = 1..16, by repeated square roots from one half
	function automatic root_tbl_t build_roots();
		root_tbl_t   t;
		logic [63:0] r;
		r = 64'd1 << 29;
		for (int k = 0; k < FRAC_STEPS; k++) begin
			r = isqrt64(r << 30);
			t[k] = r[ROOT_W-1:0];
		end
		return t;
	endfunction

	localparam root_tbl_t ROOT_TBL = build_roots();

endpackage

`default_nettype wire

// File: rtl/dcs_ram.sv
// dcs_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module dcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/dcs_ctrl.sv
// dcs_ctrl: sequencing state machine of the dtw curve similarity core
// depends on dcs_pkg; drives dcs_datapath through cmd_t and reads sts_t
`default_nettype none

module dcs_ctrl import dcs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [MODE_W-1:0] in_mode,
	output logic                   in_ready,
	input  wire sts_t              sts,
	output cmd_t                   cmd
);

	state_t     state_q;
	state_t     nxt;
	logic [4:0] step_q;

	// state and loop counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= nxt;
			step_q  <= (nxt == state_q) ? step_q + 5'd1 : 5'd0;
		end
	end

	// next state and commands
	always_comb begin
		nxt      = state_q;
		cmd      = '0;
		cmd.step = step_q[3:0];
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (mode_t'(in_mode))
						MODE_LOAD_A: begin
							if (sts.drop_a) begin
								cmd.mark_drop = 1'b1;
							end else begin
								cmd.capture = 1'b1;
								nxt = S_LN;
							end
						end
						MODE_STREAM_B: begin
							if (sts.drop_b) begin
								cmd.mark_drop = 1'b1;
							end else begin
								cmd.capture = 1'b1;
								nxt = S_LN;
							end
						end
						MODE_FINISH: begin
							nxt = sts.empty ? S_OUT : S_FREAD;
						end
						default: ;
					endcase
				end
			end
			S_LN: begin
				cmd.ln_step = 1'b1;
				if (step_q == 5'(FRAC_STEPS - 1))
					nxt = S_LNFIN;
			end
			S_LNFIN: begin
				cmd.ln_fin = 1'b1;
				nxt = sts.load_a ? S_ASTORE : S_USTART;
			end
			S_ASTORE: begin
				cmd.a_store = 1'b1;
				nxt = S_IDLE;
			end
			S_USTART: begin
				cmd.upd_start = 1'b1;
				nxt = S_UPD;
			end
			S_UPD: begin
				cmd.upd_step = 1'b1;
				if (sts.upd_fin) begin
					cmd.upd_done = 1'b1;
					nxt = S_IDLE;
				end
			end
			S_FREAD: begin
				cmd.fin_read = 1'b1;
				nxt = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == 5'(DIV_STEPS - 1))
					nxt = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				nxt = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				nxt = S_EXP;
			end
			S_EXP: begin
				cmd.exp_step = 1'b1;
				if (step_q == 5'(FRAC_STEPS - 1))
					nxt = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.clear = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/dcs_datapath.sv
// dcs_datapath: log unit, dp column cell, divider, decay unit and output register
// depends on dcs_pkg and dcs_ram; steered by dcs_ctrl through cmd_t
`default_nettype none

module dcs_datapath import dcs_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic [MODE_W-1:0] in_mode,
	input  wire logic [LAT_W-1:0] in_latency,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic [COST_W-1:0]     out_distance,
	output logic [SIM_W-1:0]      out_similarity,
	output logic                  out_empty,
	output logic                  out_overflow
);

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);

	// control state
	logic [CW-1:0]   count_a_q;
	logic [CW-1:0]   count_b_q;
	logic            dropped_q;
	logic            col0_inf_q;
	logic            out_valid_q;
	logic [CW:0]     rd_idx_q;
	logic            pend_s1;

	// payload state
	mode_t             mode_q;
	logic [MANT_W-1:0] m_q;
	logic [4:0]        p_q;
	logic [15:0]       frac_q;
	logic [LOG_W-1:0]  ln_q;
	logic [AW-1:0]     waddr_s1;
	logic [COST_W-1:0] up_q;
	logic [COST_W-1:0] diag_q;
	logic [COST_W-1:0] dist_q;
	logic [COST_W-1:0] quo_q;
	logic [CW-1:0]     rem_q;
	logic [24:0]       t_q;
	logic [30:0]       y_q;
	logic [MANT_W-1:0] acc_q;
	logic [COST_W-1:0] out_dist_q;
	logic [SIM_W-1:0]  out_sim_q;
	logic              out_empty_q;
	logic              out_ovf_q;

	// ram ports
	logic [LOG_W-1:0]  logs_rd;
	logic [COST_W-1:0] col_rd;
	logic [CW:0]       idx_m1;
	logic [CW-1:0]     last_a;
	logic [AW-1:0]     col_raddr;
	logic              issue;
	logic              col_we;

	// log unit signals
	logic [24:0]       v;
	logic [4:0]        p_enc;
	logic [54:0]       m_shift;
	logic [61:0]       sq_full;
	logic [31:0]       sq;
	logic [20:0]       l2;
	logic [36:0]       ln_prod;

	// cell signals
	logic [LOG_W-1:0]  la;
	logic [LOG_W-1:0]  d;
	logic [COST_W-1:0] left;
	logic [COST_W-1:0] min_lu;
	logic [COST_W-1:0] min3;
	logic [COST_W:0]   cell_sum;
	logic [COST_W-1:0] cell_new;

	// divider and decay signals
	logic [CW-1:0]     len;
	logic [CW:0]       trial;
	logic              fit;
	logic [41:0]       t_prod;
	logic [42:0]       y_prod;
	logic [60:0]       acc_prod;
	logic [3:0]        fidx;
	logic [14:0]       q;
	logic [31:0]       rnd_sum;
	logic [31:0]       res;
	logic [SIM_W-1:0]  sim_val;
	logic              empty;

	// ln(1+x): normalize 1+x into a q1.30 mantissa
	assign v = {1'b0, in_latency} + 25'd256;
	always_comb begin
		p_enc = 5'd8;
		for (int i = 8; i < 25; i++) begin
			if (v[i])
				p_enc = 5'(i);
		end
	end
	assign m_shift = {30'd0, v} << (5'd30 - p_enc);

	// one squaring per cycle yields one fraction bit of log2
	assign sq_full = m_q * m_q;
	assign sq      = sq_full[61:30];

	// log2 to ln with rounding
	assign l2      = {p_q - 5'd8, frac_q};
	assign ln_prod = 37'(l2) * 37'(LN2_Q16) + (37'd1 << 19);

	// column sweep addressing
	assign idx_m1    = rd_idx_q - 1'b1;
	assign last_a    = count_a_q - 1'b1;
	assign issue     = rd_idx_q <= {1'b0, count_a_q};
	assign col_raddr = cmd.fin_read ? last_a[AW-1:0] : idx_m1[AW-1:0];
	assign col_we    = cmd.upd_step && pend_s1;

	// dp cell: local cost plus min of left, up and diagonal, saturating
	assign la       = logs_rd;
	assign d        = (la > ln_q) ? la - ln_q : ln_q - la;
	assign left     = (count_b_q == '0) ? INF_COST : col_rd;
	assign min_lu   = (left < up_q) ? left : up_q;
	assign min3     = (min_lu < diag_q) ? min_lu : diag_q;
	assign cell_sum = {1'b0, min3} + {9'd0, d};
	assign cell_new = cell_sum[COST_W] ? INF_COST : cell_sum[COST_W-1:0];

	dcs_ram #(
		.WIDTH (LOG_W),
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_logs_ram (
		.clk   (clk),
		.we    (cmd.a_store),
		.waddr (count_a_q[AW-1:0]),
		.wdata (ln_q),
		.raddr (idx_m1[AW-1:0]),
		.rdata (logs_rd)
	);

	dcs_ram #(
		.WIDTH (COST_W),
		.DEPTH (MAX_LEN),
		.AW    (AW)
	) u_col_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (waddr_s1),
		.wdata (cell_new),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	// restoring divider, one quotient bit per cycle
	assign len   = (count_a_q > count_b_q) ? count_a_q : count_b_q;
	assign trial = {rem_q, quo_q[COST_W-1]};
	assign fit   = trial >= {1'b0, len};

	// scale to exponent base two
	assign t_prod = 42'(quo_q) * 42'(K_Q16) + (42'd1 << 15);
	assign y_prod = 43'(t_q) * 43'(LOG2E_Q16) + (43'd1 << 11);

	// fraction bits of 2^-y, one root factor per cycle
	assign fidx     = 4'(FRAC_STEPS - 1) - cmd.step;
	assign acc_prod = 61'(acc_q) * 61'(ROOT_TBL[cmd.step]) + (61'd1 << 29);

	// integer part of y as a rounded shift
	assign q       = y_q[30:16];
	assign rnd_sum = {1'b0, acc_q} + (32'd1 << (5'd13 + q[4:0]));
	assign res     = rnd_sum >> (5'd14 + q[4:0]);
	always_comb begin
		if (q > 15'd16)
			sim_val = '0;
		else if (res > 32'd65535)
			sim_val = '1;
		else
			sim_val = res[SIM_W-1:0];
	end

	assign empty = (count_a_q == '0) || (count_b_q == '0);

	// status to controller
	always_comb begin
		sts.drop_a   = (count_a_q >= LEN_MAX) || (count_b_q != '0);
		sts.drop_b   = count_b_q >= LEN_MAX;
		sts.empty    = empty;
		sts.load_a   = mode_q == MODE_LOAD_A;
		sts.upd_fin  = !issue && !pend_s1;
		sts.out_free = !out_valid_q || out_ready;
	end

	// counts, flags and sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q   <= '0;
			count_b_q   <= '0;
			dropped_q   <= 1'b0;
			col0_inf_q  <= 1'b0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mark_drop)
				dropped_q <= 1'b1;
			if (cmd.a_store)
				count_a_q <= count_a_q + 1'b1;
			if (cmd.upd_done)
				count_b_q <= count_b_q + 1'b1;
			if (cmd.upd_start) begin
				col0_inf_q <= 1'b1;
				rd_idx_q   <= (CW+1)'(1);
				pend_s1    <= 1'b0;
			end else if (cmd.upd_step) begin
				if (issue)
					rd_idx_q <= rd_idx_q + 1'b1;
				pend_s1 <= issue;
			end
			if (cmd.clear) begin
				count_a_q  <= '0;
				count_b_q  <= '0;
				dropped_q  <= 1'b0;
				col0_inf_q <= 1'b0;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= mode_t'(in_mode);
			m_q    <= m_shift[MANT_W-1:0];
			p_q    <= p_enc;
		end
		if (cmd.ln_step) begin
			frac_q <= {frac_q[14:0], sq[31]};
			m_q    <= sq[31] ? sq[31:1] : sq[30:0];
		end
		if (cmd.ln_fin)
			ln_q <= ln_prod[35:20];
		if (cmd.upd_start) begin
			diag_q <= col0_inf_q ? INF_COST : '0;
			up_q   <= INF_COST;
		end else if (cmd.upd_step) begin
			waddr_s1 <= idx_m1[AW-1:0];
			if (pend_s1) begin
				up_q   <= cell_new;
				diag_q <= left;
			end
		end
		if (cmd.div_start) begin
			dist_q <= col_rd;
			quo_q  <= col_rd;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fit ? CW'(trial - {1'b0, len}) : trial[CW-1:0];
			quo_q <= {quo_q[COST_W-2:0], fit};
		end
		if (cmd.mul1)
			t_q <= t_prod[40:16];
		if (cmd.mul2) begin
			y_q   <= y_prod[42:12];
			acc_q <= MANT_W'(1) << 30;
		end
		if (cmd.exp_step && y_q[fidx])
			acc_q <= acc_prod[60:30];
		if (cmd.out_load) begin
			out_dist_q  <= empty ? INF_COST : dist_q;
			out_sim_q   <= empty ? '0 : sim_val;
			out_empty_q <= empty;
			out_ovf_q   <= dropped_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_distance   = out_dist_q;
	assign out_similarity = out_sim_q;
	assign out_empty      = out_empty_q;
	assign out_overflow   = out_ovf_q;

endmodule

`default_nettype wire

// File: rtl/dtw_curve_similarity_core.sv
// dtw_curve_similarity_core: top level of the dtw latency curve comparator
// depends on dcs_pkg, dcs_ctrl, dcs_datapath (and dcs_ram inside the datapath)
`default_nettype none

// Compares two latency curves by dynamic time warping. Beats with tuser 0 load curve A
// samples, tuser 1 stream curve B samples, tuser 2 finishes and emits one result beat,
// then clears both curves; tuser 3 is ignored. One beat is taken at a time. A curve A
// load passes through accept, the squaring log unit, round and store. A curve B sample
// runs the log unit, then one dp cell per cycle through the column ram and a pipeline
// fill. A finish runs a column read, a bit-serial divider, two multiplies and the
// root-factor exponent unit; an empty curve goes straight to the output register. The
// result sits in an output register, so a new beat is taken while it waits, but a
// following finish holds until it is taken. Samples beyond MAX_LEN, and curve A samples
// after curve B started, are dropped and raise the overflow flag of the next result.
module dtw_curve_similarity_core import dcs_pkg::*; #(
	parameter int MAX_LEN = DEF_MAX_LEN
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [23:0] latency
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // [23:0] distance, [39:24] similarity,
	                                    // [40] empty_curve, [41] overflow, [47:42] zero
);

	cmd_t              cmd;
	sts_t              sts;
	logic [COST_W-1:0] distance;
	logic [SIM_W-1:0]  similarity;
	logic              empty_curve;
	logic              overflow;

	dcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_mode  (s_tuser),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dcs_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.in_mode        (s_tuser),
		.in_latency     (s_tdata),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_distance   (distance),
		.out_similarity (similarity),
		.out_empty      (empty_curve),
		.out_overflow   (overflow)
	);

	// result beat packing
	assign m_tdata = {6'd0, overflow, empty_curve, similarity, distance};

	// an empty result carries infinite distance and zero similarity
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && empty_curve |-> distance == INF_COST && similarity == '0)
		else $error("empty result with finite distance");

	// commands that end an item never coincide
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.a_store, cmd.upd_done, cmd.out_load, cmd.mark_drop}))
		else $error("conflicting end-of-item commands");

	// a loaded result is presented next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("result lost after load");

	// no beat is taken while the datapath is sweeping the column
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_step |-> !s_tready)
		else $error("input taken during column sweep");

endmodule

`default_nettype wire
